### rtl/core/top_k_class_selector_core_defines.svh
// ----------------------------------------------------------------------------
// Top-k class selector: assertion macros
// Shared property shorthands for the selector core checks.
// ----------------------------------------------------------------------------
`ifndef TOP_K_CLASS_SELECTOR_CORE_DEFINES_SVH
`define TOP_K_CLASS_SELECTOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TKCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TKCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tkcs_pkg.sv
// ----------------------------------------------------------------------------
// Top-k class selector package
// Shared types, register indexes and defaults.
// ----------------------------------------------------------------------------
package tkcs_pkg;

  localparam int unsigned MAX_K_DEF = 16;

  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned RANK_W    = 6;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_COUNT = 2'd1;

  localparam logic [CFG_W-1:0] CLASS_COUNT_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] WANTED_COUNT_RST = 16'd5;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic insert;  // take the score into the list
    logic emit;    // drive list head out and shift the list up
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic run_end;    // the score on the port is the last of its run
    logic emit_last;  // current emission is the final one of the run
  } sts_t;

endpackage

### rtl/core/tkcs_ctrl.sv
// ----------------------------------------------------------------------------
// Top-k class selector controller
// Sequences score collection and result emission.
// ----------------------------------------------------------------------------
module tkcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  tkcs_pkg::sts_t sts,
  output tkcs_pkg::cmd_t cmd,
  output logic           busy
);

  tkcs_pkg::state_t state;
  tkcs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tkcs_pkg::ST_IDLE: begin
        if (start && sts.run_end) begin
          state_next = tkcs_pkg::ST_EMIT;
        end
      end
      tkcs_pkg::ST_EMIT: begin
        if (sts.emit_last) begin
          state_next = tkcs_pkg::ST_IDLE;
        end
      end
      default: state_next = tkcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.insert = 1'b0;
    cmd.emit   = 1'b0;
    busy       = 1'b0;
    unique case (state)
      tkcs_pkg::ST_IDLE: begin
        cmd.insert = start;
      end
      tkcs_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        busy     = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

### rtl/core/tkcs_datapath.sv
// ----------------------------------------------------------------------------
// Top-k class selector datapath
// Sorted list with parallel compare-and-shift insertion, output registers.
// ----------------------------------------------------------------------------
module tkcs_datapath #(
  parameter int unsigned MAX_K = tkcs_pkg::MAX_K_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tkcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tkcs_pkg::CFG_W-1:0]            cfg_data,
  input  logic signed [tkcs_pkg::SCORE_W-1:0]   score,
  input  tkcs_pkg::cmd_t                        cmd,
  output tkcs_pkg::sts_t                        sts,
  output logic [tkcs_pkg::INDEX_W-1:0]          class_index,
  output logic signed [tkcs_pkg::SCORE_W-1:0]   class_score,
  output logic [tkcs_pkg::RANK_W-1:0]           rank,
  output logic                                  final_res,
  output logic                                  result_strobe
);

  localparam int unsigned FILL_W = $clog2(MAX_K + 1);
  localparam int unsigned CNT_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam logic [tkcs_pkg::CFG_W-1:0] MAX_K_CFG = tkcs_pkg::CFG_W'(MAX_K);
  localparam logic [FILL_W-1:0]          MAX_K_FILL = FILL_W'(MAX_K);

  logic [tkcs_pkg::CFG_W-1:0]   class_count;
  logic [tkcs_pkg::CFG_W-1:0]   wanted_count;

  logic signed [tkcs_pkg::SCORE_W-1:0] best_scores  [MAX_K];
  logic [tkcs_pkg::INDEX_W-1:0]        best_indices [MAX_K];
  logic [FILL_W-1:0]                   fill_count;
  logic [tkcs_pkg::INDEX_W-1:0]        arrival_index;
  logic [CNT_W-1:0]                    rank_cnt;
  logic [FILL_W-1:0]                   emit_n;

  logic [MAX_K-1:0]             keep;
  logic [tkcs_pkg::CFG_W-1:0]   count_eff;
  logic [tkcs_pkg::CFG_W-1:0]   real_k;
  logic [FILL_W-1:0]            fill_next;
  logic [FILL_W-1:0]            emit_n_next;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count  <= tkcs_pkg::CLASS_COUNT_RST;
      wanted_count <= tkcs_pkg::WANTED_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == tkcs_pkg::CFG_CLASS_COUNT) begin
        class_count <= cfg_data;
      end
      if (cfg_index == tkcs_pkg::CFG_WANTED_COUNT) begin
        wanted_count <= cfg_data;
      end
    end
  end

  // Run bookkeeping and clamp of k.
  always_comb begin
    count_eff = (class_count == '0) ? tkcs_pkg::CFG_W'(1) : class_count;
    sts.run_end = ({1'b0, arrival_index} + 17'd1) >= {1'b0, count_eff};
    real_k = wanted_count;
    if (real_k > count_eff) begin
      real_k = count_eff;
    end
    if (real_k == '0) begin
      real_k = tkcs_pkg::CFG_W'(1);
    end
    if (real_k > MAX_K_CFG) begin
      real_k = MAX_K_CFG;
    end
    fill_next   = (fill_count == MAX_K_FILL) ? fill_count : fill_count + FILL_W'(1);
    emit_n_next = (real_k < tkcs_pkg::CFG_W'(fill_next)) ? FILL_W'(real_k) : fill_next;
    sts.emit_last = (FILL_W'(rank_cnt) + FILL_W'(1)) == emit_n;
  end

  // Entry i holds if it outranks the new score; ties favor the older entry.
  genvar gi;
  generate
    for (gi = 0; gi < MAX_K; gi++) begin : g_entry
      assign keep[gi] = (FILL_W'(gi) < fill_count) && (best_scores[gi] >= score);

      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (!keep[gi]) begin
            if (gi == 0) begin
              best_scores[gi]  <= score;
              best_indices[gi] <= arrival_index;
            end else if (keep[(gi == 0) ? 0 : gi - 1]) begin
              best_scores[gi]  <= score;
              best_indices[gi] <= arrival_index;
            end else begin
              best_scores[gi]  <= best_scores[(gi == 0) ? 0 : gi - 1];
              best_indices[gi] <= best_indices[(gi == 0) ? 0 : gi - 1];
            end
          end
        end else if (cmd.emit && (gi + 1 < MAX_K)) begin
          // Advance the list toward the head.
          best_scores[gi]  <= best_scores[(gi + 1 < MAX_K) ? gi + 1 : gi];
          best_indices[gi] <= best_indices[(gi + 1 < MAX_K) ? gi + 1 : gi];
        end
      end
    end
  endgenerate

  // Counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      arrival_index <= '0;
      rank_cnt      <= '0;
      emit_n        <= '0;
    end else if (cmd.insert) begin
      fill_count <= fill_next;
      if (sts.run_end) begin
        arrival_index <= '0;
        rank_cnt      <= '0;
        emit_n        <= emit_n_next;
      end else begin
        arrival_index <= arrival_index + tkcs_pkg::INDEX_W'(1);
      end
    end else if (cmd.emit) begin
      rank_cnt <= rank_cnt + CNT_W'(1);
      if (sts.emit_last) begin
        fill_count <= '0;
      end
    end
  end

  // Output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      class_index <= best_indices[0];
      class_score <= best_scores[0];
      rank        <= tkcs_pkg::RANK_W'(rank_cnt);
      final_res   <= sts.emit_last;
    end
  end

endmodule

### rtl/core/top_k_class_selector_core.sv
// A non-final score is absorbed while busy stays low.
// Throughput: one score per cycle within a run, set by the parallel
// compare-and-shift insertion over all list entries.
// Run end: busy while the pairs are emitted, results one per cycle; the
// first leaves the list head in the emit state, then the output registers.
// Reset: counters cleared, list not reset, class_count 1000, wanted_count 5.
// ----------------------------------------------------------------------------
// Top-k class selector core
// Streams class scores, keeps the best MAX_K sorted, emits top k at run end.
// ----------------------------------------------------------------------------
`include "top_k_class_selector_core_defines.svh"

module top_k_class_selector_core #(
  parameter int unsigned MAX_K = tkcs_pkg::MAX_K_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [tkcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tkcs_pkg::CFG_W-1:0]          cfg_data,
  // Score request
  input  logic                                start,
  input  logic signed [tkcs_pkg::SCORE_W-1:0] score,
  output logic                                busy,
  // Results
  output logic                                result_strobe,
  output logic [tkcs_pkg::INDEX_W-1:0]        class_index,
  output logic signed [tkcs_pkg::SCORE_W-1:0] class_score,
  output logic [tkcs_pkg::RANK_W-1:0]         rank,
  output logic                                final_res
);

  tkcs_pkg::cmd_t cmd;
  tkcs_pkg::sts_t sts;

  // The controller only looks at start while idle, so a request is taken
  // exactly when start is high and busy is low.
  tkcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: configuration, sorted list, clamp of k, output registers.
  // The list drains from its head during emission, one pair per cycle.
  tkcs_datapath #(
    .MAX_K (MAX_K)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .score         (score),
    .cmd           (cmd),
    .sts           (sts),
    .class_index   (class_index),
    .class_score   (class_score),
    .rank          (rank),
    .final_res     (final_res),
    .result_strobe (result_strobe)
  );

  // Every busy cycle emits a pair on the next cycle.
  `TKCS_ASSERT_NEXT(a_busy_emits, busy, result_strobe, "busy cycle without a result")

  // The final pair of a run releases busy.
  `TKCS_ASSERT_IMP(a_final_frees, result_strobe && final_res, !busy, "busy after final pair")

  // A run's first pair carries rank zero.
  `TKCS_ASSERT_IMP(a_first_rank, result_strobe && !$past(result_strobe), rank == '0,
                   "first pair of a run not ranked zero")

endmodule
